// ----- rtl/hnbsp_pkg.sv -----
// Package for the HDLC NRZI bit-stuffing byte packer.
// Encoder state and result bundle types, plus the shared constants.
// No dependencies.
package hnbsp_pkg;

    localparam logic [7:0] RUN_STUFF  = 8'd5;
    localparam logic [7:0] SLOT0_MASK = 8'h80;
    localparam int unsigned MAX_RES   = 3;

    typedef logic [1:0] res_cnt_t;

    typedef struct packed {
        logic       level;
        logic [7:0] run;
        logic [2:0] pos;
        logic [7:0] cur;
    } enc_state_t;

    typedef struct packed {
        res_cnt_t                  cnt;
        logic [MAX_RES-1:0][7:0]   bytes;
        logic [MAX_RES-1:0]        last;
    } res_bundle_t;

    typedef struct packed {
        enc_state_t  st;
        res_bundle_t res;
    } enc_work_t;

endpackage

// ----- rtl/hnbsp_if.sv -----
// Valid/ready channel interfaces for the packer: input bytes and packed results.
// No dependencies.
interface hnbsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       no_stuff;
    logic       frame_start;
    logic       frame_end;

    modport source (output valid, data_byte, no_stuff, frame_start, frame_end, input ready);
    modport sink   (input valid, data_byte, no_stuff, frame_start, frame_end, output ready);
endinterface

interface hnbsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       frame_last;

    modport source (output valid, packed_byte, frame_last, input ready);
    modport sink   (input valid, packed_byte, frame_last, output ready);
endinterface

// ----- rtl/hnbsp_enc.sv -----
// Combinational bit chain: NRZI coding, zero insertion and byte packing of one byte.
// Depends on hnbsp_pkg.
module hnbsp_enc
    import hnbsp_pkg::*;
(
    input  enc_state_t  st,
    input  logic [7:0]  data_byte,
    input  logic        no_stuff,
    input  logic        frame_start,
    input  logic        frame_end,
    output enc_state_t  st_next,
    output res_bundle_t res
);

    function automatic enc_work_t put_line_bit(enc_work_t w);
        enc_work_t o;
        o = w;
        o.st.pos = o.st.pos + 3'd1;
        if (o.st.pos == 3'd0)
        begin
            o.res.bytes[o.res.cnt] = o.st.cur;
            o.res.last[o.res.cnt]  = 1'b0;
            o.res.cnt              = o.res.cnt + 2'd1;
            o.st.cur               = '0;
        end
        if (o.st.level)
        begin
            o.st.cur = o.st.cur | (SLOT0_MASK >> o.st.pos);
        end
        return o;
    endfunction

    always_comb
    begin
        enc_work_t w;
        w.st  = st;
        w.res = '0;
        if (frame_start)
        begin
            w.st.level = 1'b1;
            w.st.pos   = '0;
            w.st.cur   = '0;
        end
        for (int k = 0; k < 8; k++)
        begin
            if (!data_byte[k])
            begin
                w.st.level = ~w.st.level;
                w.st.run   = '0;
            end
            else
            begin
                w.st.run = w.st.run + 8'd1;
            end
            w = put_line_bit(w);
            if (!no_stuff && (w.st.run == RUN_STUFF))
            begin
                w.st.run   = '0;
                w.st.level = ~w.st.level;
                w = put_line_bit(w);
            end
        end
        if (frame_end)
        begin
            w.res.bytes[w.res.cnt] = w.st.cur;
            w.res.last[w.res.cnt]  = 1'b1;
            w.res.cnt              = w.res.cnt + 2'd1;
            w.st.pos               = '0;
            w.st.cur               = '0;
        end
        st_next = w.st;
        res     = w.res;
    end

endmodule

// ----- rtl/hnbsp_res.sv -----
// Result register: holds up to three bytes of one item; sends one per cycle while ready.
// Depends on hnbsp_pkg and hnbsp_out_if.
module hnbsp_res
    import hnbsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  res_bundle_t        bundle,
    output logic               free,
    hnbsp_out_if.source        result
);

    res_cnt_t                cnt_reg;
    res_cnt_t                idx_reg;
    logic [MAX_RES-1:0][7:0] bytes_reg;
    logic [MAX_RES-1:0]      last_reg;
    logic                    final_idx;

    assign final_idx = (idx_reg == (cnt_reg - 2'd1));
    assign free      = (cnt_reg == '0) || (result.ready && final_idx);

    assign result.valid       = (cnt_reg != '0);
    assign result.packed_byte = bytes_reg[idx_reg];
    assign result.frame_last  = last_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= bundle.cnt;
            idx_reg <= '0;
        end
        else if ((cnt_reg != '0) && result.ready)
        begin
            if (final_idx)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= bundle.bytes;
            last_reg  <= bundle.last;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (idx_reg < cnt_reg))
        else $error("result index beyond bundle count");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frame_last) |-> final_idx)
        else $error("frame end byte not last of bundle");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("bundle loaded over pending results");

endmodule

// ----- rtl/hdlc_nrzi_bit_stuff_packer_unit.sv -----
// HDLC NRZI bit-stuffing packer, top level: input register, encoder state, result register.
// Depends on hnbsp_pkg, hnbsp_if, hnbsp_enc and hnbsp_res.
// Flow: an accepted byte waits in the input register until the result register is free.
// Throughput: one byte per cycle while each byte yields at most one result and result.ready
// is high; a byte with two or three results holds the result register until all are sent.
// Reset: line level 1, ones run, bit position and partial byte cleared, no results pending.
module hdlc_nrzi_bit_stuff_packer_unit
    import hnbsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hnbsp_in_if.sink    item,
    hnbsp_out_if.source result
);

    logic        a_valid_reg;
    logic [7:0]  a_data_reg;
    logic        a_no_stuff_reg;
    logic        a_start_reg;
    logic        a_end_reg;
    enc_state_t  state_reg;
    enc_state_t  state_next;
    res_bundle_t bundle;
    logic        res_free;
    logic        adv;

    assign adv        = a_valid_reg && res_free;
    assign item.ready = !a_valid_reg || adv;

    hnbsp_enc u_enc (
        .st          (state_reg),
        .data_byte   (a_data_reg),
        .no_stuff    (a_no_stuff_reg),
        .frame_start (a_start_reg),
        .frame_end   (a_end_reg),
        .st_next     (state_next),
        .res         (bundle)
    );

    hnbsp_res u_res (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv),
        .bundle (bundle),
        .free   (res_free),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            state_reg.level <= 1'b1;
            state_reg.run   <= '0;
            state_reg.pos   <= '0;
            state_reg.cur   <= '0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            a_data_reg     <= item.data_byte;
            a_no_stuff_reg <= item.no_stuff;
            a_start_reg    <= item.frame_start;
            a_end_reg      <= item.frame_end;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && a_end_reg) |=> ((state_reg.pos == '0) && (state_reg.cur == '0)))
        else $error("frame end did not clear packing position");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> item.ready)
        else $error("input register empty but not ready");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !adv) |=> a_valid_reg)
        else $error("blocked transaction dropped from input register");

endmodule
